FILE: sv/vtms_pkg.sv
// ----------------------------------------------------------------------------
// VTOL transition mode sequencer package
// Shared types, phase codes and defaults for the transition mode sequencer.
// ----------------------------------------------------------------------------
package vtms_pkg;

   // Depth of the queue between the classify front and the phase back.
   localparam int VTMS_QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GS_LIMIT   = 3'd0;
   localparam logic [2:0] CSR_HOLD_US    = 3'd1;
   localparam logic [2:0] CSR_PITCH_F1   = 3'd2;
   localparam logic [2:0] CSR_PITCH_F2   = 3'd3;
   localparam logic [2:0] CSR_PITCH_BACK = 3'd4;

   // Configuration reset values.
   localparam logic [31:0]        RST_GS_LIMIT   = 32'd1048576;
   localparam logic [25:0]        RST_HOLD_US    = 26'd500000;
   localparam logic signed [15:0] RST_PITCH_F1   = -16'sd5734;
   localparam logic signed [15:0] RST_PITCH_F2   = -16'sd11469;
   localparam logic signed [15:0] RST_PITCH_BACK = -16'sd2048;

   // Flight phases. Code 7 is never stored.
   typedef enum logic [2:0] {
      PH_MC = 3'd0,
      PH_FW = 3'd1,
      PH_F1 = 3'd2,
      PH_F2 = 3'd3,
      PH_F3 = 3'd4,
      PH_BK = 3'd5,
      PH_B3 = 3'd6
   } phase_type;

   // Coarse vehicle modes.
   localparam logic [1:0] MODE_ROTARY = 2'd0;
   localparam logic [1:0] MODE_FIXED  = 2'd1;
   localparam logic [1:0] MODE_TO_FW  = 2'd2;
   localparam logic [1:0] MODE_TO_MC  = 2'd3;

   // One control tick on the input channel.
   typedef struct packed {
      logic               wing_request;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] vel_north;
      logic signed [15:0] vel_east;
      logic               ground_permit;
      logic [31:0]        now_us;
   } req_type;

   // One result on the output channel.
   typedef struct packed {
      logic [2:0] flight_phase;
      logic [1:0] coarse_mode;
      logic       in_transition;
      logic       in_front_one;
   } rsp_type;

   // Configuration register set.
   typedef struct packed {
      logic [31:0]        gs_limit;
      logic [25:0]        hold_us;
      logic signed [15:0] pitch_f1;
      logic signed [15:0] pitch_f2;
      logic signed [15:0] pitch_back;
   } cfg_type;

   // A classified tick as it travels from the front to the back.
   typedef struct packed {
      logic        wing_request;
      logic        ground_permit;
      logic [31:0] now_us;
      logic [30:0] north_sq;
      logic [30:0] east_sq;
      logic        pitch_f1_ok;
      logic        pitch_f2_ok;
      logic        pitch_back_ok;
   } tick_type;

endpackage

FILE: sv/vtms_front.sv
// ----------------------------------------------------------------------------
// VTOL sequencer front
// Accepts control ticks, squares the velocity components and evaluates the
// pitch tests, and holds the classified tick until the queue takes it.
// ----------------------------------------------------------------------------
module vtms_front
   import vtms_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   output logic     push,
   output tick_type push_data,
   input  logic     queue_full
);

   logic     stage_valid_ff;
   logic     stage_valid_in;
   tick_type stage_ff;
   tick_type stage_in;
   logic     load;
   logic [15:0] north_mag;
   logic [15:0] east_mag;
   logic [31:0] north_prod;
   logic [31:0] east_prod;

   // The stage stalls only while it holds a tick the queue cannot take.
   assign req_stall = stage_valid_ff && queue_full;
   assign load      = req_valid && !req_stall;
   assign push      = stage_valid_ff && !queue_full;
   assign push_data = stage_ff;

   // Magnitudes; the most negative value maps to 32768, which fits 16 bits.
   assign north_mag = req_data.vel_north[15] ? (~req_data.vel_north + 16'd1)
                                             : req_data.vel_north;
   assign east_mag  = req_data.vel_east[15] ? (~req_data.vel_east + 16'd1)
                                            : req_data.vel_east;
   assign north_prod = north_mag * north_mag;
   assign east_prod  = east_mag * east_mag;

   // Classify the incoming tick.
   always_comb begin
      stage_in.wing_request  = req_data.wing_request;
      stage_in.ground_permit = req_data.ground_permit;
      stage_in.now_us        = req_data.now_us;
      stage_in.north_sq      = north_prod[30:0];
      stage_in.east_sq       = east_prod[30:0];
      stage_in.pitch_f1_ok   = $signed(req_data.pitch_angle) <= $signed(cfg.pitch_f1);
      stage_in.pitch_f2_ok   = $signed(req_data.pitch_angle) <= $signed(cfg.pitch_f2);
      stage_in.pitch_back_ok = $signed(req_data.pitch_angle) >= $signed(cfg.pitch_back);
   end

   assign stage_valid_in = load || (stage_valid_ff && !push);

   // Stage valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

FILE: sv/vtms_queue.sv
// ----------------------------------------------------------------------------
// VTOL sequencer queue
// Short first-in first-out queue of classified ticks between front and back.
// ----------------------------------------------------------------------------
module vtms_queue
   import vtms_pkg::*;
#(
   parameter int QueueDepth = VTMS_QUEUE_DEPTH
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  tick_type push_data,
   output logic     full,
   input  logic     pop,
   output tick_type pop_data,
   output logic     not_empty
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(QueueDepth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(QueueDepth);

   tick_type            mem_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff;
   logic [PtrWidth-1:0] wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff;
   logic [PtrWidth-1:0] rd_ptr_in;
   logic [CntWidth-1:0] count_ff;
   logic [CntWidth-1:0] count_in;

   assign full      = (count_ff == CntFull);
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage is written at the write pointer only.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/vtms_back.sv
// ----------------------------------------------------------------------------
// VTOL sequencer back
// Moves the phase register one classified tick at a time and presents the
// resulting phase, mode and flags in the output register.
// ----------------------------------------------------------------------------
module vtms_back
   import vtms_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     tick_valid,
   input  tick_type tick,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [31:0] hold_start_ff;
   logic [31:0] hold_start_in;
   logic        front_one_ff;
   logic        front_one_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;
   logic [31:0] ground_sq;
   logic        speed_ok;
   logic [31:0] elapsed;
   logic        hold_done;

   // A tick is taken whenever the output register is free or being emptied.
   assign pop       = tick_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Ground speed squared and hold timer tests, both modulo 2^32 safe.
   assign ground_sq = {1'b0, tick.north_sq} + {1'b0, tick.east_sq};
   assign speed_ok  = ground_sq > cfg.gs_limit;
   assign elapsed   = tick.now_us - hold_start_ff;
   assign hold_done = elapsed >= {6'd0, cfg.hold_us};

   // Phase transitions.
   always_comb begin
      phase_in      = phase_ff;
      hold_start_in = hold_start_ff;
      if (!tick.wing_request) begin
         case (phase_ff)
            PH_FW, PH_F2, PH_F3: begin
               phase_in = PH_BK;
            end
            PH_F1: begin
               phase_in = PH_MC;
            end
            PH_BK: begin
               if (tick.pitch_back_ok) begin
                  phase_in      = PH_B3;
                  hold_start_in = tick.now_us;
               end
            end
            PH_B3: begin
               if (hold_done) begin
                  phase_in = PH_MC;
               end
            end
            default: begin
               phase_in = PH_MC;
            end
         endcase
      end else begin
         case (phase_ff)
            PH_BK: begin
               phase_in = PH_FW;
            end
            PH_F1: begin
               if ((speed_ok && tick.pitch_f1_ok) || tick.ground_permit) begin
                  phase_in = PH_F2;
               end
            end
            PH_F2: begin
               if (tick.pitch_f2_ok) begin
                  phase_in      = PH_F3;
                  hold_start_in = tick.now_us;
               end
            end
            PH_F3: begin
               if (hold_done) begin
                  phase_in = PH_FW;
               end
            end
            PH_FW: begin
               phase_in = PH_FW;
            end
            default: begin
               // Multicopter and back phase three both restart the front path.
               phase_in = PH_F1;
            end
         endcase
      end
   end

   // Mode and flags of the new phase.
   always_comb begin
      front_one_in              = front_one_ff;
      rsp_data_in.flight_phase  = phase_in;
      rsp_data_in.coarse_mode   = MODE_ROTARY;
      rsp_data_in.in_transition = 1'b0;
      case (phase_in)
         PH_FW: begin
            rsp_data_in.coarse_mode = MODE_FIXED;
         end
         PH_F1: begin
            rsp_data_in.coarse_mode   = MODE_TO_FW;
            rsp_data_in.in_transition = 1'b1;
            front_one_in              = 1'b1;
         end
         PH_F2, PH_F3: begin
            rsp_data_in.coarse_mode   = MODE_TO_FW;
            rsp_data_in.in_transition = 1'b1;
            front_one_in              = 1'b0;
         end
         PH_BK, PH_B3: begin
            rsp_data_in.coarse_mode   = MODE_TO_MC;
            rsp_data_in.in_transition = 1'b1;
         end
         default: begin
            rsp_data_in.coarse_mode = MODE_ROTARY;
         end
      endcase
      rsp_data_in.in_front_one = front_one_in;
   end

   // Sequencer state and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MC;
         hold_start_ff <= '0;
         front_one_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff      <= phase_in;
            hold_start_ff <= hold_start_in;
            front_one_ff  <= front_one_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: sv/vtol_transition_mode_sequencer.sv
// ----------------------------------------------------------------------------
// VTOL transition mode sequencer
// Seven-phase tailsitter flight-mode sequencer with configuration registers.
// ----------------------------------------------------------------------------
// The sequencer takes one control tick per clock cycle while not stalled and
// returns one result per tick, in order. A tick is classified in the front
// stage (velocity squares and pitch tests), waits in a queue of QueueDepth
// entries, and is applied to the phase register in the back stage, whose phase
// update sets the rate of one tick per cycle. A tick passes through the front
// stage register, a queue entry and the output register. The user must write
// configuration registers through the csr port only while no tick is in
// flight; the block itself does not enforce this.
module vtol_transition_mode_sequencer
   import vtms_pkg::*;
#(
   parameter int QueueDepth = VTMS_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push;
   tick_type push_data;
   logic     queue_full;
   logic     pop;
   tick_type pop_data;
   logic     queue_not_empty;

   // Configuration register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GS_LIMIT:   cfg_in.gs_limit   = csr_wdata;
            CSR_HOLD_US:    cfg_in.hold_us    = csr_wdata[25:0];
            CSR_PITCH_F1:   cfg_in.pitch_f1   = csr_wdata[15:0];
            CSR_PITCH_F2:   cfg_in.pitch_f2   = csr_wdata[15:0];
            CSR_PITCH_BACK: cfg_in.pitch_back = csr_wdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gs_limit   <= RST_GS_LIMIT;
         cfg_ff.hold_us    <= RST_HOLD_US;
         cfg_ff.pitch_f1   <= RST_PITCH_F1;
         cfg_ff.pitch_f2   <= RST_PITCH_F2;
         cfg_ff.pitch_back <= RST_PITCH_BACK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify front.
   vtms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // Queue between front and back.
   vtms_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (queue_not_empty)
   );

   // Phase back.
   vtms_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tick_valid (queue_not_empty),
      .tick       (pop_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // No result may appear in the cycle after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The front stalls only while the queue is full.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> queue_full)
      else $error("input stalled with room in the queue");

   // From fixed wing the next result is fixed wing or back transition.
   a_fw_successor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.flight_phase == PH_FW |=>
         !rsp_valid || rsp_data.flight_phase == PH_FW || rsp_data.flight_phase == PH_BK)
      else $error("illegal phase after fixed wing");

   // From multicopter the next result is multicopter or front phase one.
   a_mc_successor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.flight_phase == PH_MC |=>
         !rsp_valid || rsp_data.flight_phase == PH_MC || rsp_data.flight_phase == PH_F1)
      else $error("illegal phase after multicopter");

endmodule
